>>> design/dcpwm_pkg.sv
// Shared constants and the prescaler table for the dual-channel PWM block.
`default_nettype none
package dcpwm_pkg;

  // Number of fitted channels and width of each period counter.
  localparam int unsigned CHANNELS   = 2;
  localparam int unsigned COUNT_BITS = 16;

  // Channels that the register map provides room for.
  localparam int unsigned MAX_CHANNELS = 2;

  localparam int unsigned PRE_BITS    = 17;
  localparam int unsigned CTRL_BITS   = 22;
  localparam int unsigned PERIOD_BITS = 32;
  localparam int unsigned PERIOD_HALF = 16;
  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned ADDR_BITS   = 4;
  localparam int unsigned IN_BYTES    = 8;
  localparam int unsigned OUT_BYTES   = 8;
  localparam int unsigned OUT_FIELDS  = 4;

  // Layout of one channel's field inside the control word.
  localparam int unsigned CTRL_STRIDE     = 15;
  localparam int unsigned CTRL_FIELD_BITS = 7;
  localparam int unsigned CODE_BITS       = 4;
  localparam int unsigned CTRL_EN_BIT     = 4;
  localparam int unsigned CTRL_POL_BIT    = 5;
  localparam int unsigned CTRL_GATE_BIT   = 6;

  // Register indexes on the configuration port (byte address / 4).
  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_PERIOD0 = 2'd1,
    REG_PERIOD1 = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  // Divisor for each prescaler code; zero stops the channel.
  localparam logic [PRE_BITS-1:0] DIV_TABLE [16] = '{
    17'd120,   17'd180,   17'd240,   17'd360,
    17'd480,   17'd0,     17'd0,     17'd0,
    17'd12000, 17'd24000, 17'd36000, 17'd48000,
    17'd72000, 17'd0,     17'd0,     17'd1
  };

  typedef struct packed {
    logic ch1_wrapped;
    logic ch0_wrapped;
    logic pin1_level;
    logic pin0_level;
  } result_t;

endpackage
`default_nettype wire

>>> design/dual_channel_pwm_with_prescaler.sv
// Top level of the dual-channel PWM generator with per-channel prescalers.
//
// Each input transfer is one oscillator tick; advance (tdata bit 0) steps the
// prescaler and period counters of every running channel, and the result
// transfer reports the pin levels after that tick and whether each period
// counter wrapped. The block takes one transfer per clock cycle while the result
// is not held up; a result passes through the input register, then the result
// register, and the input side keeps moving while a result waits as long as
// the result register is free or being emptied in the same cycle. The counter
// step of each channel, one increment and compare per counter, sits between
// those two registers. The user must write registers through the APB port only
// while no transfer is in flight; the block itself does not enforce this.
`default_nettype none
module dual_channel_pwm_with_prescaler
  import dcpwm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_BYTES-1:0]  in_tdata,    // [0] advance
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OUT_BYTES-1:0]      out_tdata,   // [0] pin0_level, [1] pin1_level,
                                                 // [2] ch0_wrapped, [3] ch1_wrapped
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [DATA_BITS-1:0] cfg_pwdata,
  output logic [DATA_BITS-1:0]      cfg_prdata,
  output logic                      cfg_pready
);

  logic [CTRL_BITS-1:0]   control_r;
  logic [PERIOD_BITS-1:0] period_r [MAX_CHANNELS];

  logic     in_valid_r;
  logic     adv_r;
  logic     out_valid_r;
  result_t  out_data_r;
  logic     step;
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  logic lvl_w  [MAX_CHANNELS];
  logic wrap_w [MAX_CHANNELS];

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_BITS-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r   <= '0;
      period_r[0] <= '0;
      period_r[1] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CONTROL: control_r   <= cfg_pwdata[CTRL_BITS-1:0];
        REG_PERIOD0: period_r[0] <= cfg_pwdata;
        REG_PERIOD1: period_r[1] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CONTROL: cfg_prdata = {{(DATA_BITS-CTRL_BITS){1'b0}}, control_r};
      REG_PERIOD0: cfg_prdata = period_r[0];
      REG_PERIOD1: cfg_prdata = period_r[1];
      default:     cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------- pipeline
  // The input register moves on whenever the result register is empty or is
  // being drained in this cycle; the counters step with that move.
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      adv_r <= in_tdata[0];
    end
  end

  // --------------------------------------------------------------- channels
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_ch
    if (c < CHANNELS) begin : g_fit
      logic [CTRL_FIELD_BITS-1:0] fld;
      logic [CODE_BITS-1:0]       code;
      logic                       en;
      logic                       pol;
      logic                       gate;
      logic [COUNT_BITS-1:0]      entire;
      logic [COUNT_BITS-1:0]      active;
      logic [PRE_BITS-1:0]        divv;
      logic [PRE_BITS-1:0]        pre_r;
      logic [PRE_BITS-1:0]        pre_nxt;
      logic [PRE_BITS-1:0]        pre_inc;
      logic [COUNT_BITS-1:0]      cyc_r;
      logic [COUNT_BITS-1:0]      cyc_nxt;
      logic                       run;
      logic                       pre_hit;

      assign fld    = control_r[c*CTRL_STRIDE +: CTRL_FIELD_BITS];
      assign code   = fld[CODE_BITS-1:0];
      assign en     = fld[CTRL_EN_BIT];
      assign pol    = fld[CTRL_POL_BIT];
      assign gate   = fld[CTRL_GATE_BIT];
      assign entire = period_r[c][PERIOD_HALF +: COUNT_BITS];
      assign active = period_r[c][0 +: COUNT_BITS];
      assign divv   = DIV_TABLE[code];

      assign run     = adv_r && gate && (divv != '0);
      assign pre_inc = PRE_BITS'(pre_r + 1'b1);
      // A count left above a smaller divisor after a code change ends the
      // prescale period at once, as does the count rolling over.
      assign pre_hit = (pre_inc >= divv) || (pre_inc == '0);

      always_comb begin
        pre_nxt   = pre_r;
        cyc_nxt   = cyc_r;
        wrap_w[c] = 1'b0;
        if (!en) begin
          pre_nxt = '0;
          cyc_nxt = '0;
        end else if (run) begin
          if (pre_hit) begin
            pre_nxt = '0;
            if (cyc_r >= entire) begin
              cyc_nxt   = '0;
              wrap_w[c] = 1'b1;
            end else begin
              cyc_nxt = COUNT_BITS'(cyc_r + 1'b1);
            end
          end else begin
            pre_nxt = pre_inc;
          end
        end
        if (!en) begin
          lvl_w[c] = !pol;
        end else begin
          lvl_w[c] = (cyc_nxt < active) ? pol : !pol;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          pre_r <= '0;
          cyc_r <= '0;
        end else if (step) begin
          pre_r <= pre_nxt;
          cyc_r <= cyc_nxt;
        end
      end
    end else begin : g_absent
      assign lvl_w[c]  = 1'b0;
      assign wrap_w[c] = 1'b0;
    end
  end

  // ----------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r.pin0_level  <= lvl_w[0];
      out_data_r.pin1_level  <= lvl_w[1];
      out_data_r.ch0_wrapped <= wrap_w[0];
      out_data_r.ch1_wrapped <= wrap_w[1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_BYTES-OUT_FIELDS){1'b0}}, out_data_r};

endmodule
`default_nettype wire

>>> design/dcpwm_checker.sv
// Port-level checker for the dual-channel PWM block and its bind statement.
`default_nettype none
module dcpwm_checker
  import dcpwm_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_tvalid,
  input wire logic                 in_tready,
  input wire logic [IN_BYTES-1:0]  in_tdata,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [OUT_BYTES-1:0] out_tdata
);

  // Nothing is left in the result register right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // Input back-pressure only comes from a result that is held up.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a stalled result");

  // Every taken tick is followed by a valid result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[0] == in_tdata[0]) |-> ##2 out_tvalid)
    else $error("no result two cycles after an input transfer");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_BYTES-1:OUT_FIELDS] == '0))
    else $error("result padding not zero");

  // A stalled result holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind dual_channel_pwm_with_prescaler dcpwm_checker u_dcpwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
